[design/rsptok_pkg.sv]
// rsptok_pkg: shared types and constants for the resp stream tokenizer
// no dependencies
`default_nettype none
package rsptok_pkg;
	localparam int MAX_DEPTH_DEF    = 8;
	localparam int HEADER_LIMIT_DEF = 31;
	localparam int LENW             = 31;

	localparam logic [63:0] SAT_MAG  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INT_MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LEN_MAXV = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SAT_DIV  = SAT_MAG / 64'd10;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLL  = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_SIMPLE    = 4'd1;
	localparam logic [3:0] EV_ERROR     = 4'd2;
	localparam logic [3:0] EV_BULK      = 4'd3;
	localparam logic [3:0] EV_SIMPLE_END = 4'd4;
	localparam logic [3:0] EV_ERROR_END = 4'd5;
	localparam logic [3:0] EV_BULK_END  = 4'd6;
	localparam logic [3:0] EV_INTEGER   = 4'd7;
	localparam logic [3:0] EV_NIL       = 4'd8;
	localparam logic [3:0] EV_BULK_START = 4'd9;
	localparam logic [3:0] EV_ARRAY_START = 4'd10;
	localparam logic [3:0] EV_PROTO_ERR = 4'd11;

	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_ERROR  = 2'd1;
	localparam logic [1:0] KIND_INT    = 2'd2;

	typedef enum logic [4:0] {
		M_TYPE   = 5'b00001,
		M_LINE   = 5'b00010,
		M_HEADER = 5'b00100,
		M_BULK   = 5'b01000,
		M_TRAIL  = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [3:0]  ev;
		logic [7:0]  txt;
		logic [63:0] num;
		logic [3:0]  nest;
		logic [3:0]  closed;
		logic        last;
	} result_t;

	typedef struct packed {
		logic            fin;
		logic            push;
		logic            clear;
		logic [LENW-1:0] push_val;
	} stk_ctl_t;
endpackage
`default_nettype wire

[design/resp_stream_tokenizer_core.sv]
// resp_stream_tokenizer_core: byte-serial tokenizer top level
// depends on rsptok_pkg, rsptok_stack, rsptok_queue
// one byte per cycle while in_ready is high; a byte's results enter the result queue with its transaction
// the result queue emits one result per cycle while out_ready is high, so a byte with two results
// takes two queue slots; in_ready drops when fewer than two slots remain
// close cascade ripples through the row of stack cells within the cycle
// arst_n clears parser state, stack depth and queue; stack counts are not reset
`default_nettype none
module resp_stream_tokenizer_core #(
	parameter int MAX_DEPTH    = rsptok_pkg::MAX_DEPTH_DEF,
	parameter int HEADER_LIMIT = rsptok_pkg::HEADER_LIMIT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              event_res,
	output logic [7:0]              text_byte,
	output logic signed [63:0]      number_value,
	output logic [3:0]              nest_level,
	output logic [3:0]              arrays_closed,
	output logic                    last
);
	import rsptok_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int HW = $clog2(HEADER_LIMIT + 2);
	localparam int CW = ($clog2(MAX_DEPTH + 2) > 4) ? $clog2(MAX_DEPTH + 2) : 4;

	typedef struct packed {
		logic [63:0]   acc;
		logic          neg;
		logic          stopped;
		logic [HW-1:0] hc;
		logic [1:0]    phase;
	} num_t;

	typedef struct packed {
		mode_t           mode;
		logic [1:0]      kind;
		logic            cr;
		num_t            ns;
		logic [LENW-1:0] rem;
		logic [1:0]      trail;
	} st_t;

	st_t      st_q, nx;
	stk_ctl_t ctl;
	result_t  r0, r1;
	logic     push0, push1, room, acc_in;
	logic [DW-1:0] depth, fin_depth, fin_closed;
	result_t  head;

	function automatic logic [3:0] sat4(input logic [CW-1:0] v);
		return (v > CW'(15)) ? 4'd15 : v[3:0];
	endfunction

	function automatic num_t num_char(input num_t s, input logic [7:0] ch);
		num_t        o;
		logic [63:0] v;
		o = s;
		v = '0;
		if (o.hc <= HW'(HEADER_LIMIT)) begin
			o.hc = o.hc + HW'(1);
		end
		if (!(o.hc > HW'(HEADER_LIMIT) || o.stopped)) begin
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				o.phase = 2'd2;
				if (o.acc > SAT_DIV) begin
					o.acc = SAT_MAG;
				end else begin
					v = (o.acc << 3) + (o.acc << 1) + {60'd0, ch[3:0]};
					o.acc = (v > SAT_MAG) ? SAT_MAG : v;
				end
			end else if (o.phase == 2'd0 &&
				(ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))) begin
				o.phase = 2'd0;
			end else if (o.phase == 2'd0 && (ch == CH_PLUS || ch == CH_MINUS)) begin
				o.neg   = ch == CH_MINUS;
				o.phase = 2'd1;
			end else begin
				o.stopped = 1'b1;
			end
		end
		return o;
	endfunction

	// a held-back cr fed to the number reader: never a digit
	function automatic num_t num_cr(input num_t s);
		num_t o;
		o = s;
		if (o.hc <= HW'(HEADER_LIMIT)) begin
			o.hc = o.hc + HW'(1);
		end
		if (!(o.hc > HW'(HEADER_LIMIT) || o.stopped) && o.phase != 2'd0) begin
			o.stopped = 1'b1;
		end
		return o;
	endfunction

	assign acc_in   = in_valid & in_ready;
	assign in_ready = room;

	always_comb begin
		logic [7:0]      c;
		logic            lb;
		logic            n1;
		logic [LENW-1:0] len;
		logic [3:0]      tev;
		logic [3:0]      nest_cur;
		logic [3:0]      nest_fin;
		c        = data_byte;
		nx       = st_q;
		lb       = 1'b0;
		n1       = 1'b0;
		r0       = '0;
		r1       = '0;
		push0    = 1'b0;
		push1    = 1'b0;
		ctl      = '0;
		len      = (st_q.ns.acc > LEN_MAXV) ? LEN_MAXV[LENW-1:0] : st_q.ns.acc[LENW-1:0];
		tev      = (st_q.kind == KIND_ERROR) ? EV_ERROR : EV_SIMPLE;
		nest_cur = sat4(CW'(depth));
		nest_fin = sat4(CW'(fin_depth));
		ctl.push_val = len;

		case (st_q.mode)
			M_TYPE: begin
				nx.cr = 1'b0;
				nx.ns = '0;
				nx.kind = KIND_SIMPLE;
				if (c == CH_PLUS) begin
					nx.mode = M_LINE;
				end else if (c == CH_MINUS) begin
					nx.mode = M_LINE;
					nx.kind = KIND_ERROR;
				end else if (c == CH_COLON) begin
					nx.mode = M_LINE;
					nx.kind = KIND_INT;
				end else if (c == CH_DOLL) begin
					nx.mode = M_HEADER;
				end else if (c == CH_STAR) begin
					nx.mode = M_HEADER;
					nx.kind = KIND_ERROR;
				end else begin
					// inline command keeps its first byte
					nx.mode = M_LINE;
					if (c == CH_CR) begin
						nx.cr = 1'b1;
					end else begin
						push0  = 1'b1;
						r0.ev  = EV_SIMPLE;
						r0.txt = c;
						r0.nest = nest_cur;
					end
				end
			end
			M_LINE, M_HEADER: begin
				lb = 1'b1;
			end
			M_BULK: begin
				if (st_q.rem <= LENW'(1)) begin
					nx.rem   = '0;
					nx.mode  = M_TRAIL;
					nx.trail = 2'd2;
				end else begin
					nx.rem = st_q.rem - LENW'(1);
				end
				push0   = 1'b1;
				r0.ev   = EV_BULK;
				r0.txt  = c;
				r0.nest = nest_cur;
			end
			M_TRAIL: begin
				if (st_q.trail <= 2'd1) begin
					nx.trail  = '0;
					nx.mode   = M_TYPE;
					ctl.fin   = 1'b1;
					push0     = 1'b1;
					r0.ev     = EV_BULK_END;
					r0.nest   = nest_fin;
					r0.closed = sat4(CW'(fin_closed));
				end else begin
					nx.trail = st_q.trail - 2'd1;
				end
			end
			default: begin
				nx.mode = M_TYPE;
			end
		endcase

		if (lb) begin
			n1 = (st_q.mode == M_LINE) && (st_q.kind != KIND_INT);
			if (st_q.cr && c == CH_LF) begin
				nx.cr = 1'b0;
				push0 = 1'b1;
				if (st_q.mode == M_LINE) begin
					nx.mode   = M_TYPE;
					ctl.fin   = 1'b1;
					r0.nest   = nest_fin;
					r0.closed = sat4(CW'(fin_closed));
					if (st_q.kind == KIND_INT) begin
						r0.ev  = EV_INTEGER;
						r0.num = st_q.ns.neg ? (~st_q.ns.acc + 64'd1) :
							((st_q.ns.acc > INT_MAXV) ? INT_MAXV : st_q.ns.acc);
					end else begin
						r0.ev = (st_q.kind == KIND_ERROR) ? EV_ERROR_END : EV_SIMPLE_END;
					end
				end else if (st_q.ns.hc > HW'(HEADER_LIMIT)) begin
					nx.mode   = M_TYPE;
					ctl.clear = 1'b1;
					r0.ev     = EV_PROTO_ERR;
				end else if (st_q.ns.neg && st_q.ns.acc != 64'd0) begin
					nx.mode   = M_TYPE;
					ctl.fin   = 1'b1;
					r0.ev     = EV_NIL;
					r0.nest   = nest_fin;
					r0.closed = sat4(CW'(fin_closed));
				end else if (st_q.kind == KIND_SIMPLE) begin
					if (len == '0) begin
						nx.mode  = M_TRAIL;
						nx.trail = 2'd2;
					end else begin
						nx.mode = M_BULK;
						nx.rem  = len;
					end
					r0.ev   = EV_BULK_START;
					r0.num  = {{(64-LENW){1'b0}}, len};
					r0.nest = nest_cur;
				end else if (len == '0) begin
					// empty array closes itself
					nx.mode   = M_TYPE;
					ctl.fin   = 1'b1;
					r0.ev     = EV_ARRAY_START;
					r0.nest   = nest_fin;
					r0.closed = sat4(CW'(fin_closed) + CW'(1));
				end else if (depth >= DW'(MAX_DEPTH)) begin
					nx.mode   = M_TYPE;
					ctl.clear = 1'b1;
					r0.ev     = EV_PROTO_ERR;
				end else begin
					nx.mode  = M_TYPE;
					ctl.push = 1'b1;
					r0.ev    = EV_ARRAY_START;
					r0.num   = {{(64-LENW){1'b0}}, len};
					r0.nest  = sat4(CW'(depth) + CW'(1));
				end
			end else if (st_q.cr) begin
				// late cr released as data, then the current byte unless it is another cr
				nx.cr = (c == CH_CR);
				if (n1) begin
					push0   = 1'b1;
					r0.ev   = tev;
					r0.txt  = CH_CR;
					r0.nest = nest_cur;
					if (c != CH_CR) begin
						push1   = 1'b1;
						r1.ev   = tev;
						r1.txt  = c;
						r1.nest = nest_cur;
					end
				end else begin
					nx.ns = num_cr(st_q.ns);
					if (c != CH_CR) begin
						nx.ns = num_char(nx.ns, c);
					end
				end
			end else if (c == CH_CR) begin
				nx.cr = 1'b1;
			end else if (n1) begin
				push0   = 1'b1;
				r0.ev   = tev;
				r0.txt  = c;
				r0.nest = nest_cur;
			end else begin
				nx.ns = num_char(st_q.ns, c);
			end
		end

		if (push1) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end

		if (!acc_in) begin
			push0 = 1'b0;
			push1 = 1'b0;
			ctl   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_TYPE, kind: '0, cr: 1'b0, ns: '0, rem: '0, trail: '0};
		end else if (acc_in) begin
			st_q <= nx;
		end
	end

	rsptok_stack #(.MAX_DEPTH(MAX_DEPTH), .DW(DW)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.depth     (depth),
		.fin_depth (fin_depth),
		.fin_closed(fin_closed)
	);

	rsptok_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push0   (push0),
		.push1   (push1),
		.d0      (r0),
		.d1      (r1),
		.pop     (out_valid & out_ready),
		.room    (room),
		.nonempty(out_valid),
		.head    (head)
	);

	assign event_res     = head.ev;
	assign text_byte     = head.txt;
	assign number_value  = head.num;
	assign nest_level    = head.nest;
	assign arrays_closed = head.closed;
	assign last          = head.last;
endmodule
`default_nettype wire

[design/rsptok_cell.sv]
// rsptok_cell: one entry of the array nesting stack, holds an element count
// depends on rsptok_pkg
`default_nettype none
module rsptok_cell #(
	parameter int IDX = 0,
	parameter int DW  = 4
) (
	input  wire logic                    clk,
	input  wire logic [DW-1:0]           depth,
	input  wire rsptok_pkg::stk_ctl_t    ctl,
	input  wire logic                    chain_in,
	output logic                         chain_out,
	output logic                         popped
);
	import rsptok_pkg::*;

	logic [LENW-1:0] cnt_q;
	logic            active;
	logic            is_one;

	assign active    = depth > DW'(IDX);
	assign is_one    = cnt_q == LENW'(1);
	assign popped    = active & chain_in & is_one;
	assign chain_out = active ? popped : chain_in;

	always_ff @(posedge clk) begin
		if (ctl.push && depth == DW'(IDX)) begin
			cnt_q <= ctl.push_val;
		end else if (ctl.fin && active && chain_in && !is_one) begin
			cnt_q <= cnt_q - LENW'(1);
		end
	end
endmodule
`default_nettype wire

[design/rsptok_stack.sv]
// rsptok_stack: row of count cells with the depth register and close cascade
// depends on rsptok_pkg and rsptok_cell
`default_nettype none
module rsptok_stack #(
	parameter int MAX_DEPTH = rsptok_pkg::MAX_DEPTH_DEF,
	parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rsptok_pkg::stk_ctl_t ctl,
	output logic [DW-1:0]             depth,
	output logic [DW-1:0]             fin_depth,
	output logic [DW-1:0]             fin_closed
);
	import rsptok_pkg::*;

	logic [DW-1:0]      depth_q;
	logic [MAX_DEPTH:0] chain;
	logic [MAX_DEPTH-1:0] popped;

	assign chain[MAX_DEPTH] = 1'b1;

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		rsptok_cell #(.IDX(i), .DW(DW)) u_cell (
			.clk      (clk),
			.depth    (depth_q),
			.ctl      (ctl),
			.chain_in (chain[i+1]),
			.chain_out(chain[i]),
			.popped   (popped[i])
		);
	end

	assign fin_closed = DW'($countones(popped));
	assign fin_depth  = depth_q - fin_closed;
	assign depth      = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.clear) begin
			depth_q <= '0;
		end else if (ctl.push) begin
			depth_q <= depth_q + DW'(1);
		end else if (ctl.fin) begin
			depth_q <= fin_depth;
		end
	end
endmodule
`default_nettype wire

[design/rsptok_queue.sv]
// rsptok_queue: four-entry result queue, takes up to two results per cycle
// depends on rsptok_pkg
`default_nettype none
module rsptok_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push0,
	input  wire logic                push1,
	input  wire rsptok_pkg::result_t d0,
	input  wire rsptok_pkg::result_t d1,
	input  wire logic                pop,
	output logic                     room,
	output logic                     nonempty,
	output rsptok_pkg::result_t      head
);
	import rsptok_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [2:0] n_in;

	assign n_in     = {1'b0, push0 & push1, push0 ^ push1};
	assign room     = cnt_q <= 3'd2;
	assign nonempty = cnt_q != 3'd0;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= d0;
		end
		if (push1) begin
			mem_q[wr_q + 2'd1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in[1:0];
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + n_in - {2'b00, pop};
		end
	end
endmodule
`default_nettype wire

[design/rsptok_checker.sv]
// rsptok_checker: port-level assertions for the tokenizer, bound to the top level
// depends on rsptok_pkg and the resp_stream_tokenizer_core ports
`default_nettype none
module rsptok_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  event_res,
	input wire logic [63:0] number_value,
	input wire logic [3:0]  nest_level,
	input wire logic [3:0]  arrays_closed
);
	import rsptok_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out transaction dropped while stalled");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res != EV_NONE && event_res <= EV_PROTO_ERR))
		else $error("event code out of range");

	a_text_no_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_SIMPLE || event_res == EV_ERROR ||
			event_res == EV_BULK)
		|-> number_value == 64'd0)
		else $error("text event carries a number");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_PROTO_ERR |-> nest_level == 4'd0 && arrays_closed == 4'd0)
		else $error("protocol error with nonempty stack");
endmodule

bind resp_stream_tokenizer_core rsptok_checker u_rsptok_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_res    (event_res),
	.number_value (number_value),
	.nest_level   (nest_level),
	.arrays_closed(arrays_closed)
);
`default_nettype wire
